[design/clnw_pkg.sv]
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types and constants for the character display 4-bit write block.
// ----------------------------------------------------------------------------
`default_nettype none

package clnw_pkg;

  // Request kinds carried on in_tuser
  localparam logic [1:0] REQ_CMD    = 2'd0;
  localparam logic [1:0] REQ_DATA   = 2'd1;
  localparam logic [1:0] REQ_CURSOR = 2'd2;

  // Register index, taken from paddr bit 2
  localparam logic REG_PULSE_TICKS = 1'b0;
  localparam logic REG_ROW1_BASE   = 1'b1;

  localparam logic [7:0]  CMD_SET_ADDR = 8'h80;
  localparam logic [3:0]  NIBBLE_MASK  = 4'hf;
  localparam logic [15:0] PULSE_RESET  = 16'd50;
  localparam logic [6:0]  ROW1_RESET   = 7'h40;

  // Live configuration
  typedef struct packed {
    logic [15:0] pulse_ticks;
    logic [6:0]  row1_base;
  } cfg_t;

  // One byte ready for the bus
  typedef struct packed {
    logic        rs;
    logic [7:0]  byte_val;
    logic [15:0] hold;
  } byte_job_t;

endpackage

`default_nettype wire

[design/clnw_cfg.sv]
// ----------------------------------------------------------------------------
// clnw_cfg
// APB-style register file: pulse_ticks and row1_base.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_cfg
  import clnw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [15:0] pulse_ticks_r;
  logic [6:0]  row1_base_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= PULSE_RESET;
      row1_base_r   <= ROW1_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_PULSE_TICKS: pulse_ticks_r <= pwdata[15:0];
        REG_ROW1_BASE:   row1_base_r   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PULSE_TICKS: prdata = {16'd0, pulse_ticks_r};
      REG_ROW1_BASE:   prdata = {25'd0, row1_base_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg.pulse_ticks = pulse_ticks_r;
  assign cfg.row1_base   = row1_base_r;

endmodule

`default_nettype wire

[design/clnw_encode.sv]
// ----------------------------------------------------------------------------
// clnw_encode
// Input register: turn a request into the byte, register select and hold.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_encode
  import clnw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  cfg_t            cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] byte_value,
  input  wire logic       row,
  input  wire logic [5:0] col,
  output logic            job_valid,
  input  wire logic       job_ready,
  output byte_job_t       job
);

  logic      job_valid_r;
  logic      job_valid_nxt;
  byte_job_t job_r;
  byte_job_t job_nxt;
  logic      keep;
  logic [6:0] addr;

  assign in_ready = !job_valid_r || job_ready;

  always_comb begin
    addr             = (row ? cfg.row1_base : 7'd0) | {1'b0, col};
    keep             = 1'b1;
    job_nxt.hold     = (cfg.pulse_ticks == 16'd0) ? 16'd1 : cfg.pulse_ticks;
    job_nxt.rs       = 1'b0;
    job_nxt.byte_val = byte_value;
    case (req_type)
      REQ_CMD:    job_nxt.rs = 1'b0;
      REQ_DATA:   job_nxt.rs = 1'b1;
      REQ_CURSOR: job_nxt.byte_val = CMD_SET_ADDR | {1'b0, addr};
      default:    keep = 1'b0;  // drop the unused kind
    endcase
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    if (in_valid && in_ready) begin
      job_valid_nxt = keep;
    end else if (job_ready) begin
      job_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

`default_nettype wire

[design/clnw_segment.sv]
// ----------------------------------------------------------------------------
// clnw_segment
// Result register: step one byte through its four enable segments.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_segment
  import clnw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  job_valid,
  output logic       job_ready,
  input  byte_job_t  job,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       reg_select,
  output logic [3:0] bus_nibble,
  output logic       enable_level,
  output logic [15:0] hold_ticks,
  output logic       last_segment
);

  typedef enum logic [1:0] {
    SEG_HI_EN,
    SEG_HI_DIS,
    SEG_LO_EN,
    SEG_LO_DIS
  } seg_t;

  logic        valid_r;
  seg_t        seg_r;
  seg_t        seg_nxt;
  logic        rs_r;
  logic [7:0]  byte_r;
  logic [15:0] hold_r;
  logic        take;
  logic        step;

  // Load a new byte when empty or when the final segment leaves
  assign take      = !valid_r || (out_ready && seg_r == SEG_LO_DIS);
  assign step      = valid_r && out_ready && seg_r != SEG_LO_DIS;
  assign job_ready = take;
  assign seg_nxt   = seg_t'(seg_r + 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      seg_r   <= SEG_HI_EN;
      rs_r    <= 1'b0;
      byte_r  <= 8'd0;
      hold_r  <= 16'd0;
    end else if (take) begin
      valid_r <= job_valid;
      seg_r   <= SEG_HI_EN;
      if (job_valid) begin
        rs_r   <= job.rs;
        byte_r <= job.byte_val;
        hold_r <= job.hold;
      end
    end else if (step) begin
      seg_r   <= seg_nxt;
    end
  end

  always_comb begin
    case (seg_r)
      SEG_HI_EN:  begin bus_nibble = byte_r[7:4];          enable_level = 1'b1; end
      SEG_HI_DIS: begin bus_nibble = byte_r[7:4];          enable_level = 1'b0; end
      SEG_LO_EN:  begin bus_nibble = byte_r[3:0] & NIBBLE_MASK; enable_level = 1'b1; end
      default:    begin bus_nibble = byte_r[3:0] & NIBBLE_MASK; enable_level = 1'b0; end
    endcase
  end

  assign out_valid    = valid_r;
  assign reg_select   = rs_r;
  assign hold_ticks   = hold_r;
  assign last_segment = (seg_r == SEG_LO_DIS);

endmodule

`default_nettype wire

[design/char_lcd_nibble_writer_top.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top
// 4-bit character display write sequencer: each request becomes four
// pin segments (high nibble E=1, E=0, low nibble E=1, E=0).
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Carries
//  in_      slave      one request: kind, byte, row, column
//  out_     master     one pin segment: RS, DB7..DB4, E, hold ticks, last
//  cfg_     APB slave  pulse_ticks (addr 0x0), row1_base (addr 0x4)
//
// Each kept request yields four results, one per cycle while out_tready
// is high, paced by the segment stepper in the result register. A request
// is registered in the input stage, then loaded into the result register,
// whose output is the first segment. A request of the unused kind is taken
// and dropped. Reset is synchronous, active low, and empties both stages;
// the registers return to pulse_ticks 50 and row1_base 0x40. The input stage
// takes the next request while segments of the current byte still wait.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_writer_top
  import clnw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] byte_value, [8] row, [14:9] col, [15] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  // segment channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [3:0] bus_nibble, [4] enable_level,
                                       // [20:5] hold_ticks, [23:21] zero
  output logic             out_tuser,  // [0] reg_select
  output logic             out_tlast,  // last_segment
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t        cfg;
  logic        job_valid;
  logic        job_ready;
  byte_job_t   job;
  logic [3:0]  bus_nibble;
  logic        enable_level;
  logic [15:0] hold_ticks;

  clnw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input stage: resolve the byte to send and capture the hold time
  clnw_encode u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req_type   (in_tuser),
    .byte_value (in_tdata[7:0]),
    .row        (in_tdata[8]),
    .col        (in_tdata[14:9]),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job)
  );

  // Result stage: walk the byte through its four segments
  clnw_segment u_segment (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .reg_select   (out_tuser),
    .bus_nibble   (bus_nibble),
    .enable_level (enable_level),
    .hold_ticks   (hold_ticks),
    .last_segment (out_tlast)
  );

  assign out_tdata = {3'd0, hold_ticks, enable_level, bus_nibble};

endmodule

`default_nettype wire

[sim/tb_char_lcd_nibble_writer_top.sv]
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_writer_top
// Self-checking bench for the 4-bit character display write sequencer.
// Requests are sent in bursts with random gaps, and the segment channel
// stalls in changing patterns. Every accepted segment is checked against
// a local model of the display bus. The configuration is reprogrammed over
// APB between phases, including its extremes, and read back each time.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_char_lcd_nibble_writer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clnw_pkg::*;

  // The package names three request kinds; the fourth code is unused.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 32;

  // One pin segment as seen on the result channel
  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic        en;
    logic [15:0] hold;
    logic        last;
  } segment_t;

  // One row of the directed table; bus_byte and rs are typed in when known
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       row;
    logic [5:0] col;
    logic       typed;
    logic       rs;
    logic [7:0] bus_byte;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] byte_value, [8] row, [14:9] col, [15] zero
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [3:0] bus_nibble, [4] enable_level, [20:5] hold_ticks, [23:21] zero
  logic        out_tuser;  // [0] reg_select
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Local copy of the configuration, changed only while the block is idle
  logic [15:0] pulse_cfg;
  logic [6:0]  row1_cfg;

  // Segments still owed by the block, oldest first
  segment_t pending_segments[$];
  dir_row_t dir_rows[$];

  // Typed-in expectation of the request currently on the input channel
  logic       typed_now;
  logic       typed_rs;
  logic [7:0] typed_byte;

  int err_cnt = 0;

  char_lcd_nibble_writer_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Display bus model
  // --------------------------------------------------------------------------

  // Return {rs, byte} that a request puts on the bus. A cursor move ORs the
  // row base with the column, so overlapping bits merge rather than carry.
  function automatic logic [8:0] bus_byte_for(input logic [1:0] kind,
                                              input logic [7:0] value,
                                              input logic       row,
                                              input logic [5:0] col);
    logic [6:0] addr;
    addr = (row ? row1_cfg : 7'd0) | {1'b0, col};
    case (kind)
      REQ_CMD:    return {1'b0, value};
      REQ_DATA:   return {1'b1, value};
      default:    return {1'b0, CMD_SET_ADDR | {1'b0, addr}};
    endcase
  endfunction

  // Queue the four segments of one byte: high nibble E=1, E=0, then low
  // nibble E=1, E=0. A zero pulse count is held as one tick.
  function automatic void queue_segments(input logic rs, input logic [7:0] b);
    logic [15:0] hold;
    hold = (pulse_cfg == 16'd0) ? 16'd1 : pulse_cfg;
    pending_segments.push_back('{rs, b[7:4], 1'b1, hold, 1'b0});
    pending_segments.push_back('{rs, b[7:4], 1'b0, hold, 1'b0});
    pending_segments.push_back('{rs, b[3:0], 1'b1, hold, 1'b0});
    pending_segments.push_back('{rs, b[3:0], 1'b0, hold, 1'b1});
  endfunction

  function automatic void note_failure(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: check segments leaving, predict for requests entering
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    segment_t   got;
    segment_t   want;
    logic [8:0] rs_byte;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[3:0], out_tdata[4], out_tdata[20:5], out_tlast};
        if (pending_segments.size() == 0) begin
          note_failure($sformatf("unexpected segment rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                                 got.rs, got.nibble, got.en, got.hold, got.last));
        end else begin
          want = pending_segments.pop_front();
          if (got !== want)
            note_failure($sformatf({"segment mismatch: expected rs=%0d nib=%h en=%0d hold=%0d ",
                                    "last=%0d, got rs=%0d nib=%h en=%0d hold=%0d last=%0d"},
                                   want.rs, want.nibble, want.en, want.hold, want.last,
                                   got.rs, got.nibble, got.en, got.hold, got.last));
        end
      end
      // Drop the unused kind: it yields no segment.
      if (in_tvalid && in_tready && in_tuser != REQ_UNUSED) begin
        if (typed_now) begin
          queue_segments(typed_rs, typed_byte);
        end else begin
          rs_byte = bus_byte_for(in_tuser, in_tdata[7:0], in_tdata[8], in_tdata[14:9]);
          queue_segments(rs_byte[8], rs_byte[7:0]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall in one of four patterns, each chosen at random and changed at random
  // --------------------------------------------------------------------------
  initial begin : receiver
    int   mode;
    int   mode_left;
    int   run_left;
    logic lvl;
    mode = 0;
    mode_left = 0;
    run_left = 0;
    lvl = 1'b1;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 120);
        run_left = 0;
      end
      mode_left--;
      case (mode)
        0: out_tready <= 1'b1;                      // no stalls at all
        1: out_tready <= 1'($urandom_range(0, 1));  // coin flip per cycle
        2: out_tready <= (mode_left % 4) != 0;      // periodic single stalls
        default: begin                              // long stalls, short runs
          if (run_left == 0) begin
            lvl = ~lvl;
            run_left = lvl ? $urandom_range(1, 6) : $urandom_range(1, 12);
          end
          run_left--;
          out_tready <= lvl;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender and configuration tasks
  // --------------------------------------------------------------------------

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic [1:0] kind, input logic [7:0] value,
                              input logic row, input logic [5:0] col,
                              input logic typed, input logic rs, input logic [7:0] b);
    @(negedge clk);
    in_tvalid  <= 1'b1;
    in_tuser   <= kind;
    in_tdata   <= {1'b0, col, row, value};
    typed_now  = typed;
    typed_rs   = rs;
    typed_byte = b;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid for a gap whose length is set by n.
  task automatic pause_sender(input int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold off until every owed segment has come, then let the pipeline
  // settle in case an unused request is still passing through.
  task automatic wait_drained();
    pause_sender(1);
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic cfg_access(input logic wr, input logic reg_idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_register(input logic reg_idx, input logic [31:0] want);
    logic [31:0] rd;
    cfg_access(1'b0, reg_idx, 32'd0, rd);
    if (rd !== want)
      note_failure($sformatf("register %0d readback: expected %h, got %h", reg_idx, want, rd));
  endtask

  task automatic program_register(input logic reg_idx, input logic [31:0] value);
    logic [31:0] unused_rd;
    cfg_access(1'b1, reg_idx, value, unused_rd);
    if (reg_idx == REG_PULSE_TICKS) begin
      pulse_cfg = value[15:0];
      check_register(reg_idx, {16'd0, pulse_cfg});
    end else begin
      row1_cfg = value[6:0];
      check_register(reg_idx, {25'd0, row1_cfg});
    end
  endtask

  task automatic add_row(input logic [1:0] kind, input logic [7:0] value, input logic row,
                         input logic [5:0] col, input logic typed, input logic rs,
                         input logic [7:0] b);
    dir_rows.push_back('{kind, value, row, col, typed, rs, b});
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    dir_row_t    r;
    logic [1:0]  kind;
    logic [15:0] pulse;
    logic [6:0]  row1;
    int          burst_left;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_CMD;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    typed_now   = 1'b0;
    typed_rs    = 1'b0;
    typed_byte  = '0;
    pulse_cfg   = PULSE_RESET;
    row1_cfg    = ROW1_RESET;
    burst_left  = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Registers come out of reset at their documented values.
    check_register(REG_PULSE_TICKS, {16'd0, PULSE_RESET});
    check_register(REG_ROW1_BASE,   {25'd0, ROW1_RESET});

    // Directed part, at reset configuration (row base 0x40, 50 ticks).
    // Byte extremes for both command and data, row/col ignored outside moves.
    add_row(REQ_CMD,    8'h00, 1'b0, 6'd0,  1'b1, 1'b0, 8'h00);
    add_row(REQ_CMD,    8'hff, 1'b0, 6'd0,  1'b1, 1'b0, 8'hff);
    add_row(REQ_DATA,   8'h00, 1'b0, 6'd0,  1'b1, 1'b1, 8'h00);
    add_row(REQ_DATA,   8'hff, 1'b1, 6'd63, 1'b1, 1'b1, 8'hff);
    add_row(REQ_DATA,   8'ha5, 1'b1, 6'd63, 1'b1, 1'b1, 8'ha5);
    add_row(REQ_CMD,    8'h5a, 1'b1, 6'd42, 1'b1, 1'b0, 8'h5a);
    // Cursor moves: corners of the address space, byte field ignored.
    add_row(REQ_CURSOR, 8'hff, 1'b0, 6'd0,  1'b1, 1'b0, 8'h80);
    add_row(REQ_CURSOR, 8'h00, 1'b0, 6'd63, 1'b1, 1'b0, 8'hbf);
    add_row(REQ_CURSOR, 8'h00, 1'b1, 6'd0,  1'b1, 1'b0, 8'hc0);
    add_row(REQ_CURSOR, 8'hff, 1'b1, 6'd63, 1'b1, 1'b0, 8'hff);
    // Unused kind: taken and dropped, nothing owed.
    add_row(REQ_UNUSED, 8'hff, 1'b1, 6'd63, 1'b1, 1'b0, 8'h00);
    add_row(REQ_UNUSED, 8'h00, 1'b0, 6'd0,  1'b1, 1'b0, 8'h00);
    // Ordinary traffic, predicted.
    add_row(REQ_DATA,   8'h48, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00);
    add_row(REQ_DATA,   8'h69, 1'b1, 6'd5,  1'b0, 1'b0, 8'h00);
    add_row(REQ_CMD,    8'h28, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00);
    add_row(REQ_CMD,    8'h0c, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00);
    add_row(REQ_CMD,    8'h01, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00);
    add_row(REQ_CURSOR, 8'h33, 1'b1, 6'h15, 1'b0, 1'b0, 8'h00);
    add_row(REQ_CURSOR, 8'h00, 1'b0, 6'h2a, 1'b0, 1'b0, 8'h00);
    add_row(REQ_DATA,   8'h7e, 1'b0, 6'h3f, 1'b0, 1'b0, 8'h00);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_request(r.kind, r.value, r.row, r.col, r.typed, r.rs, r.bus_byte);
      // Leave an occasional gap so the directed items also see idle input.
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 3));
    end

    // Random phases, each under its own configuration. The first ones hit
    // the extremes: zero pulse (held as one tick), one tick, the maximum,
    // a full row base that overlaps every column bit, and a zero base.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin pulse = 16'd0;       row1 = 7'h7f; end
        1: begin pulse = 16'd1;       row1 = 7'h00; end
        2: begin pulse = 16'hffff;    row1 = 7'h20; end
        3: begin pulse = PULSE_RESET; row1 = ROW1_RESET; end
        default: begin
          pulse = 16'($urandom_range(1, 65535));
          row1  = 7'($urandom_range(0, 127));
        end
      endcase
      wait_drained();
      program_register(REG_PULSE_TICKS, {16'd0, pulse});
      program_register(REG_ROW1_BASE,   {25'd0, row1});
      typed_now = 1'b0;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          pause_sender($urandom_range(1, 6));
          burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        kind = ($urandom_range(0, 9) == 0) ? REQ_UNUSED : 2'($urandom_range(0, 2));
        send_request(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     6'($urandom_range(0, 63)), 1'b0, 1'b0, 8'h00);
        // Halfway through one phase, hold the sender until the block is empty.
        if (ph == 3 && n == ITEMS_PER_PHASE / 2) wait_drained();
      end
    end

    wait_drained();
    if (err_cnt == 0 && pending_segments.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: end the run as failed once it reaches CYCLE_LIMIT.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
